### rtl/core/ffbta_pkg.sv
// Shared constants for the first-fit boundary-tag allocator core.
// Depends on nothing; used by the allocator top level.
package ffbta_pkg;

  localparam int MAX_GRANULES  = 4096;
  localparam int GRANULE_BYTES = 16;
  localparam int TAG_BYTES     = 4;

  localparam int ADDR_W   = $clog2(MAX_GRANULES);   // header store index
  localparam int SIZE_W   = 13;                     // block size in granules
  localparam int HDR_W    = SIZE_W + 1;             // size plus used bit
  localparam int ARENA_W  = 13;                     // configuration register
  localparam int BYTES_W  = 16;                     // request and offset width
  localparam int GRAN_SH  = $clog2(GRANULE_BYTES);

  localparam int NEED_BIAS = 2 * TAG_BYTES + GRANULE_BYTES - 1;

  // Granules needed for a request: payload plus both tags, rounded up.
  function automatic logic [SIZE_W-1:0] need_granules(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W:0] sum;
    sum = {1'b0, bytes} + (BYTES_W+1)'(NEED_BIAS);
    return SIZE_W'(sum >> GRAN_SH);
  endfunction

endpackage

### rtl/core/first_fit_boundary_tag_allocator_core.sv
// First-fit boundary-tag allocator: top level with header walk sequencer.
// Depends on ffbta_pkg and ffbta_ram.
//
// Usage:
//  - Request channel: drive request_bytes and raise start; the transaction is
//    taken at a rising edge with start high and busy low.
//  - Result: done is high for exactly one cycle with payload_offset and failed.
//    The receiver cannot stall; the result must be taken in that cycle.
//  - Configuration: arena_granules is written at an edge with cfg_valid and
//    cfg_ready high. cfg_ready is high only while idle and start is low.
//    A write of at least two granules reformats the arena as one free block.
//  - Timing: each block header visited passes through a memory read state,
//    then an evaluate state, since the header store has registered read data.
//    When a visited header fits, done is set on leaving the evaluate state, or
//    on leaving the split state when the chosen block is split. Reaching the
//    end marker sets done on leaving the read state, and a corrupt header fails
//    in the evaluate state. The next request can be taken at the edge that ends
//    the done cycle. A request with no valid arena answers failed on the next cycle.
//  - Reset (rst, synchronous): sets the arena size to 4096 granules and
//    formats the arena; busy is high meanwhile.
module first_fit_boundary_tag_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffbta_pkg::BYTES_W-1:0] request_bytes,
  output logic                          done,
  output logic [ffbta_pkg::BYTES_W-1:0] payload_offset,
  output logic                          failed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffbta_pkg::ARENA_W-1:0] arena_granules
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FMT   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EV    = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;

  localparam int AW = ffbta_pkg::ADDR_W;
  localparam int SW = ffbta_pkg::SIZE_W;
  localparam int HW = ffbta_pkg::HDR_W;

  logic [2:0]                    state;
  logic [ffbta_pkg::ARENA_W-1:0] arena;
  logic                          arena_valid;
  logic [AW-1:0]                 end_idx;
  logic [AW-1:0]                 g;
  logic [SW-1:0]                 need;
  logic [AW-1:0]                 split_addr;
  logic [SW-1:0]                 rem;

  logic          we;
  logic [AW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic [HW-1:0] rdata;

  // Format arithmetic: clamp the arena to the store depth
  logic [ffbta_pkg::ARENA_W-1:0] arena_n;
  logic [SW-1:0]                 arena_last;
  logic                          fmt_valid;

  // Header evaluation
  logic [SW-1:0] hdr_size;
  logic          hdr_used;
  logic [SW-1:0] room;
  logic          chain_bad;
  logic          fits;
  logic [SW-1:0] g_ext;

  assign arena_n    = (arena > ffbta_pkg::ARENA_W'(ffbta_pkg::MAX_GRANULES))
                      ? ffbta_pkg::ARENA_W'(ffbta_pkg::MAX_GRANULES) : arena;
  assign arena_last = SW'(arena_n - ffbta_pkg::ARENA_W'(1));
  assign fmt_valid  = (arena_n >= ffbta_pkg::ARENA_W'(2));

  assign hdr_size  = rdata[HW-1:1];
  assign hdr_used  = rdata[0];
  assign g_ext     = SW'(g);
  assign room      = SW'(end_idx) - g_ext;
  assign chain_bad = (hdr_size == '0) || (hdr_size > room);
  assign fits      = !hdr_used && (hdr_size >= need);

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;

  always_comb begin
    we    = 1'b0;
    waddr = g;
    wdata = {need, 1'b1};
    case (state)
      ST_FMT: begin
        we    = fmt_valid;
        waddr = '0;
        wdata = {arena_last, 1'b0};
      end
      ST_EV: begin
        we    = !chain_bad && fits;
        waddr = g;
        wdata = {need, 1'b1};
      end
      ST_SPLIT: begin
        we    = 1'b1;
        waddr = split_addr;
        wdata = {rem, 1'b0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ffbta_ram #(
    .WIDTH(HW),
    .DEPTH(ffbta_pkg::MAX_GRANULES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(g),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FMT;
      arena       <= ffbta_pkg::ARENA_W'(ffbta_pkg::MAX_GRANULES);
      arena_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            arena <= arena_granules;
            state <= ST_FMT;
          end else if (start) begin
            need <= ffbta_pkg::need_granules(request_bytes);
            g    <= '0;
            if (arena_valid) begin
              state <= ST_RD;
            end else begin
              done           <= 1'b1;
              failed         <= 1'b1;
              payload_offset <= '0;
            end
          end
        end
        ST_FMT: begin
          arena_valid <= fmt_valid;
          end_idx     <= fmt_valid ? AW'(arena_last) : '0;
          state       <= ST_IDLE;
        end
        ST_RD: begin
          // Reaching the end marker ends the walk without a fit
          if (g >= end_idx) begin
            done           <= 1'b1;
            failed         <= 1'b1;
            payload_offset <= '0;
            state          <= ST_IDLE;
          end else begin
            state <= ST_EV;
          end
        end
        ST_EV: begin
          if (chain_bad) begin
            done           <= 1'b1;
            failed         <= 1'b1;
            payload_offset <= '0;
            state          <= ST_IDLE;
          end else if (fits) begin
            payload_offset <= ffbta_pkg::BYTES_W'(
                                {g_ext + SW'(1), {ffbta_pkg::GRAN_SH{1'b0}}});
            failed         <= 1'b0;
            split_addr     <= AW'(g_ext + need);
            rem            <= hdr_size - need;
            if (hdr_size > need) begin
              state <= ST_SPLIT;
            end else begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end else begin
            // Advance to the next block header
            g     <= AW'(g_ext + hdr_size);
            state <= ST_RD;
          end
        end
        ST_SPLIT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/ffbta_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ffbta_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
